// ===== sv/fsbs_pkg.sv =====
// Shared field widths, operation codes, status codes and register addresses for the bottom-swap stack.
package fsbs_pkg;

   // Fixed field widths of the transaction ports
   localparam int OP_BITS       = 3;
   localparam int DATA_BITS     = 32;
   localparam int FILL_BITS     = 11;
   localparam int STATUS_BITS   = 2;
   localparam int CSR_ADDR_BITS = 2;
   localparam int CSR_DATA_BITS = 32;

   // Largest value the capacity register can hold
   localparam int FILL_MAX = (1 << FILL_BITS) - 1;

   typedef logic [OP_BITS-1:0]     op_type;
   typedef logic [STATUS_BITS-1:0] status_type;

   // Operation codes
   localparam op_type OP_PUSH        = 3'd0;
   localparam op_type OP_PUSH_BOTTOM = 3'd1;
   localparam op_type OP_POP         = 3'd2;
   localparam op_type OP_POP_N       = 3'd3;
   localparam op_type OP_POP_BOTTOM  = 3'd4;
   localparam op_type OP_ERASE       = 3'd5;
   localparam op_type OP_READ_TOP    = 3'd6;
   localparam op_type OP_CLEAR       = 3'd7;

   // Status codes
   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_OVER  = 2'd1;
   localparam status_type ST_UNDER = 2'd2;
   localparam status_type ST_RANGE = 2'd3;

   // Register addresses
   localparam logic [CSR_ADDR_BITS-1:0] CSR_CAPACITY = 2'd0;

endpackage

// ===== sv/fsbs_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module fsbs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/fixed_stack_with_bottom_swap.sv =====
// Bounded stack with bottom swap and erase-by-fill, held in one synchronous RAM.
// Push, pop n with no refetch, read top and clear go straight to the response state; pop,
// pop n, pop bottom and erase pass through fetch and wait when a new top must be read from
// the RAM; push bottom on a non-empty stack passes through swap read and swap write (read
// bottom, write bottom, write top). Transactions are taken one at a time, and a response
// still waiting on rsp_ready holds the sequencer in its done state.
// Reset clears fill, control state and restores capacity; the RAM contents are not cleared.
module fixed_stack_with_bottom_swap #(
   parameter int DEPTH     = 1024,
   parameter int WORD_BITS = 32
) (
   input  logic                                      clock,
   input  logic                                      reset,
   // request channel
   input  logic                                      req_valid,
   output logic                                      req_ready,
   input  logic [fsbs_pkg::OP_BITS-1:0]              req_operation,
   input  logic signed [fsbs_pkg::DATA_BITS-1:0]     req_value,
   input  logic [fsbs_pkg::FILL_BITS-1:0]            req_amount_or_position,
   // response channel
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output logic signed [fsbs_pkg::DATA_BITS-1:0]     rsp_top_word,
   output logic [fsbs_pkg::FILL_BITS-1:0]            rsp_fill,
   output logic [fsbs_pkg::STATUS_BITS-1:0]          rsp_status,
   // register port
   input  logic                                      csr_psel,
   input  logic                                      csr_penable,
   input  logic                                      csr_pwrite,
   input  logic [fsbs_pkg::CSR_ADDR_BITS-1:0]        csr_paddr,
   input  logic [fsbs_pkg::CSR_DATA_BITS-1:0]        csr_pwdata,
   output logic [fsbs_pkg::CSR_DATA_BITS-1:0]        csr_prdata,
   output logic                                      csr_pready
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = (CW > fsbs_pkg::FILL_BITS) ? CW : fsbs_pkg::FILL_BITS;
   localparam int PW = (WORD_BITS > fsbs_pkg::DATA_BITS) ? WORD_BITS : fsbs_pkg::DATA_BITS;
   localparam int CAP_RESET = (DEPTH > fsbs_pkg::FILL_MAX) ? fsbs_pkg::FILL_MAX : DEPTH;

   // sequencer states
   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_FETCH   = 3'd1;
   localparam logic [2:0] S_WAIT    = 3'd2;
   localparam logic [2:0] S_SWAP_RD = 3'd3;
   localparam logic [2:0] S_SWAP_WR = 3'd4;
   localparam logic [2:0] S_DONE    = 3'd5;

   logic [2:0]                           state_ff, state_in;
   logic [CW-1:0]                        count_ff, count_in;
   logic [WORD_BITS-1:0]                 top_ff, top_in;
   logic [WORD_BITS-1:0]                 word_ff, word_in;
   fsbs_pkg::status_type                 status_ff, status_in;
   logic [fsbs_pkg::FILL_BITS-1:0]       cap_ff;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [fsbs_pkg::DATA_BITS-1:0]       rsp_top_ff, rsp_top_in;
   logic [fsbs_pkg::FILL_BITS-1:0]       rsp_fill_ff, rsp_fill_in;
   fsbs_pkg::status_type                 rsp_status_ff, rsp_status_in;

   logic                                 mem_we, mem_re;
   logic [AW-1:0]                        mem_waddr, mem_raddr;
   logic [WORD_BITS-1:0]                 mem_wdata, mem_rdata;

   logic [XW-1:0]                        count_x, arg_x, cap_x, eff_cap;
   logic [CW-1:0]                        count_dec;
   logic [PW-1:0]                        value_x, top_x;
   logic [WORD_BITS-1:0]                 req_word;
   logic                                 full, empty, csr_wr;

   // state RAM
   fsbs_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // capacity register
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == fsbs_pkg::CSR_CAPACITY) ?
                       fsbs_pkg::CSR_DATA_BITS'(cap_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= fsbs_pkg::FILL_BITS'(CAP_RESET);
      end else if (csr_wr && csr_paddr == fsbs_pkg::CSR_CAPACITY) begin
         cap_ff <= csr_pwdata[fsbs_pkg::FILL_BITS-1:0];
      end
   end

   // fill checks against the capacity, saturated at the RAM depth
   assign count_x   = XW'(count_ff);
   assign arg_x     = XW'(req_amount_or_position);
   assign cap_x     = XW'(cap_ff);
   assign eff_cap   = (cap_x > XW'(DEPTH)) ? XW'(DEPTH) : cap_x;
   assign full      = (count_x >= eff_cap);
   assign empty     = (count_ff == '0);
   assign count_dec = count_ff - 1'b1;

   // pushed word is the low bits of the value, zero-extended where the RAM is wider
   assign value_x  = PW'(unsigned'(req_value));
   assign req_word = value_x[WORD_BITS-1:0];
   assign top_x    = PW'(top_ff);

   assign req_ready = (state_ff == S_IDLE);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      top_in        = top_ff;
      word_in       = word_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_top_in    = rsp_top_ff;
      rsp_fill_in   = rsp_fill_ff;
      rsp_status_in = rsp_status_ff;
      mem_we        = 1'b0;
      mem_waddr     = '0;
      mem_wdata     = '0;
      mem_re        = 1'b0;
      mem_raddr     = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               word_in   = req_word;
               status_in = fsbs_pkg::ST_OK;
               state_in  = S_DONE;
               unique case (req_operation)
                  fsbs_pkg::OP_PUSH: begin
                     if (full) begin
                        status_in = fsbs_pkg::ST_OVER;
                     end else begin
                        mem_we    = 1'b1;
                        mem_waddr = count_ff[AW-1:0];
                        mem_wdata = req_word;
                        top_in    = req_word;
                        count_in  = count_ff + 1'b1;
                     end
                  end
                  fsbs_pkg::OP_PUSH_BOTTOM: begin
                     if (full) begin
                        status_in = fsbs_pkg::ST_OVER;
                     end else if (empty) begin
                        mem_we    = 1'b1;
                        mem_wdata = req_word;
                        top_in    = req_word;
                        count_in  = CW'(1);
                     end else begin
                        // fetch the old bottom entry first
                        mem_re   = 1'b1;
                        state_in = S_SWAP_RD;
                     end
                  end
                  fsbs_pkg::OP_POP: begin
                     if (empty) begin
                        status_in = fsbs_pkg::ST_UNDER;
                     end else begin
                        count_in = count_dec;
                        if (count_dec != '0) begin
                           state_in = S_FETCH;
                        end
                     end
                  end
                  fsbs_pkg::OP_POP_N: begin
                     if (arg_x > count_x) begin
                        status_in = fsbs_pkg::ST_UNDER;
                     end else begin
                        count_in = CW'(count_x - arg_x);
                        if (arg_x != '0 && arg_x < count_x) begin
                           state_in = S_FETCH;
                        end
                     end
                  end
                  fsbs_pkg::OP_POP_BOTTOM: begin
                     if (empty) begin
                        status_in = fsbs_pkg::ST_UNDER;
                     end else begin
                        // top entry moves into slot 0
                        mem_we    = 1'b1;
                        mem_wdata = top_ff;
                        count_in  = count_dec;
                        if (count_dec != '0) begin
                           state_in = S_FETCH;
                        end
                     end
                  end
                  fsbs_pkg::OP_ERASE: begin
                     if (arg_x >= count_x) begin
                        status_in = fsbs_pkg::ST_RANGE;
                     end else begin
                        // top entry fills the hole
                        mem_we    = 1'b1;
                        mem_waddr = arg_x[AW-1:0];
                        mem_wdata = top_ff;
                        count_in  = count_dec;
                        if (count_dec != '0) begin
                           state_in = S_FETCH;
                        end
                     end
                  end
                  fsbs_pkg::OP_READ_TOP: begin
                     if (empty) begin
                        status_in = fsbs_pkg::ST_UNDER;
                     end
                  end
                  fsbs_pkg::OP_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         // read the new top once any write from the request has landed
         S_FETCH: begin
            mem_re    = 1'b1;
            mem_raddr = count_dec[AW-1:0];
            state_in  = S_WAIT;
         end
         S_WAIT: begin
            top_in   = mem_rdata;
            state_in = S_DONE;
         end
         // old bottom arrives: it becomes the top, new word goes to slot 0
         S_SWAP_RD: begin
            top_in    = mem_rdata;
            mem_we    = 1'b1;
            mem_wdata = word_ff;
            state_in  = S_SWAP_WR;
         end
         S_SWAP_WR: begin
            mem_we    = 1'b1;
            mem_waddr = count_ff[AW-1:0];
            mem_wdata = top_ff;
            count_in  = count_ff + 1'b1;
            state_in  = S_DONE;
         end
         // publish once the output register is free
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_top_in    = empty ? '0 : top_x[fsbs_pkg::DATA_BITS-1:0];
               rsp_fill_in   = count_x[fsbs_pkg::FILL_BITS-1:0];
               rsp_status_in = status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      top_ff        <= top_in;
      word_ff       <= word_in;
      status_ff     <= status_in;
      rsp_top_ff    <= rsp_top_in;
      rsp_fill_ff   <= rsp_fill_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_top_word = signed'(rsp_top_ff);
   assign rsp_fill     = rsp_fill_ff;
   assign rsp_status   = rsp_status_ff;

endmodule

// ===== sv/fsbs_checker.sv =====
// Port-level checks for the bottom-swap stack, bound to the top level.
module fsbs_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_ready,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic signed [fsbs_pkg::DATA_BITS-1:0] rsp_top_word,
   input logic [fsbs_pkg::FILL_BITS-1:0]        rsp_fill,
   input logic [fsbs_pkg::STATUS_BITS-1:0]      rsp_status
);

   // reset leaves no response pending and the request side open
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("response pending or request blocked after reset");

   // one transaction at a time: an accepted request closes the request side
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while another is in flight");

   // an empty stack reports a zero top word
   a_empty_top_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fill == '0 |-> rsp_top_word == '0)
      else $error("nonzero top word on empty stack");

   // a stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_top_word) &&
                                  $stable(rsp_fill) && $stable(rsp_status))
      else $error("stalled response changed");

endmodule

bind fixed_stack_with_bottom_swap fsbs_checker u_fsbs_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_top_word (rsp_top_word),
   .rsp_fill     (rsp_fill),
   .rsp_status   (rsp_status)
);
